FILE: sv/fws_pkg.sv
// shared types, constants and state codes of the focal weighted window sum
package fws_pkg;

  localparam int MAX_COLS    = 1024;
  localparam int MAX_HALF    = 2;
  localparam int SAMPLE_BITS = 16;
  localparam int WEIGHT_FRAC = 12;
  localparam int WEIGHT_BITS = 16;
  localparam int SPAN        = 2 * MAX_HALF + 1;
  localparam int SLOTS       = 2 * MAX_HALF;
  localparam int NUM_WEIGHTS = SPAN * SPAN;
  localparam int SUM_BITS    = 40;

  localparam int COL_W   = $clog2(MAX_COLS);
  localparam int CCNT_W  = COL_W + 1;
  localparam int ROW_W   = 16;
  localparam int OUT_W   = 26;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int SPAN_W  = $clog2(SPAN);
  localparam int WIDX_W  = 5;
  localparam int HALF_W  = 2;

  typedef struct packed {
    logic                          na;
    logic signed [SAMPLE_BITS-1:0] value;
  } entry_t;

  typedef enum logic [1:0] {
    CMD_WEIGHT = 2'd0,
    CMD_PIXEL  = 2'd1,
    CMD_FLUSH  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    REG_COLUMN_COUNT = 3'd0,
    REG_ROW_COUNT    = 3'd1,
    REG_HALF_ROWS    = 3'd2,
    REG_HALF_COLS    = 3'd3,
    REG_SKIP_NA      = 3'd4,
    REG_FILL_NA_ONLY = 3'd5
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_SHIFT,
    ST_CHECK,
    ST_DIV,
    ST_MAC,
    ST_MAC_END,
    ST_EMIT,
    ST_FLUSH
  } state_t;

endpackage

FILE: sv/fws_line_slot.sv
// one row slot of the line store: single write port, registered read
module fws_line_slot import fws_pkg::*; (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [COL_W-1:0] wr_addr,
  input  entry_t           wr_data,
  input  logic             rd_en,
  input  logic [COL_W-1:0] rd_addr,
  output entry_t           rd_data
);

  entry_t mem [MAX_COLS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/fws_row_cell.sv
// one window row: taps shift toward index 0, the new entry enters at the top
module fws_row_cell import fws_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  shift,
  input  entry_t                din,
  output entry_t [SPAN-1:0]     taps
);

  always_ff @(posedge clk) begin
    if (rst) begin
      taps <= '0;
    end else if (shift) begin
      for (int k = 0; k < SPAN - 1; k++) begin
        taps[k] <= taps[k+1];
      end
      taps[SPAN-1] <= din;
    end
  end

endmodule

FILE: sv/fws_divider.sv
// restoring divider, one quotient bit per cycle, for output position row and column
module fws_divider import fws_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [OUT_W-1:0]  dividend,
  input  logic [CCNT_W-1:0] divisor,
  output logic              done,
  output logic [OUT_W-1:0]  quotient,
  output logic [CCNT_W-1:0] remainder
);

  localparam int STEP_W = $clog2(OUT_W + 1);

  logic [STEP_W-1:0] steps;
  logic              busy;
  logic [CCNT_W:0]   trial;
  logic              fits;

  assign trial = {remainder, quotient[OUT_W-1]};
  assign fits  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(OUT_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
    end else if (busy) begin
      quotient <= {quotient[OUT_W-2:0], fits};
      if (fits) begin
        remainder <= CCNT_W'(trial - {1'b0, divisor});
      end else begin
        remainder <= trial[CCNT_W-1:0];
      end
    end
  end

endmodule

FILE: sv/focal_weighted_sum_na_core.sv
// top level of the focal weighted window sum over a streamed raster frame
//
// raster pixels stream in row order; each gives at most one result, the weighted
// sum of the window centred on the pixel half_rows*column_count+half_cols pixels
// earlier. one transaction is handled at a time. a pixel whose result is due
// runs the 26-step divider that places the output pixel in the frame; a border
// NA or a passed-through centre is then emitted, else the single
// multiply-accumulate unit walks the window one tap a cycle. a transaction with
// a result waits while the output register is stalled. a finished result waits
// in the output register while the next transaction is taken. the window is a
// chain of row cells shifted once per pixel, fed from four line slots of 1024
// entries, each with a single write port. configuration must be written only
// while idle; the block itself does not enforce it.

module focal_weighted_sum_na_core import fws_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        cfg_write,
  input  logic [2:0]                  cfg_index,
  input  logic [15:0]                 cfg_data,
  // item channel
  input  logic                        item_valid,
  output logic                        item_stall,
  input  logic [1:0]                  cmd,
  input  logic [WIDX_W-1:0]           weight_index,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                        sample_na,
  // result channel
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic signed [SUM_BITS-1:0]  sum_value,
  output logic                        sum_na,
  output logic                        frame_last
);

  // configuration registers
  logic [CCNT_W-1:0] column_count;
  logic [ROW_W-1:0]  row_count;
  logic [HALF_W-1:0] half_rows;
  logic [HALF_W-1:0] half_cols;
  logic              skip_na;
  logic              fill_na_only;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= CCNT_W'(MAX_COLS);
      row_count    <= ROW_W'(1024);
      half_rows    <= HALF_W'(1);
      half_cols    <= HALF_W'(1);
      skip_na      <= 1'b0;
      fill_na_only <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_COLUMN_COUNT: column_count <= cfg_data[CCNT_W-1:0];
        REG_ROW_COUNT:    row_count    <= cfg_data[ROW_W-1:0];
        REG_HALF_ROWS:    half_rows    <= cfg_data[HALF_W-1:0];
        REG_HALF_COLS:    half_cols    <= cfg_data[HALF_W-1:0];
        REG_SKIP_NA:      skip_na      <= cfg_data[0];
        REG_FILL_NA_ONLY: fill_na_only <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // effective frame geometry: zero columns or rows act as one, columns and half sizes saturate
  logic [CCNT_W-1:0] cols;
  logic [ROW_W-1:0]  rows;
  logic [HALF_W-1:0] hr;
  logic [HALF_W-1:0] hc;

  always_comb begin
    if (column_count == '0) begin
      cols = CCNT_W'(1);
    end else if (column_count > CCNT_W'(MAX_COLS)) begin
      cols = CCNT_W'(MAX_COLS);
    end else begin
      cols = column_count;
    end
    rows = (row_count == '0) ? ROW_W'(1) : row_count;
    hr   = (half_rows > HALF_W'(MAX_HALF)) ? HALF_W'(MAX_HALF) : half_rows;
    hc   = (half_cols > HALF_W'(MAX_HALF)) ? HALF_W'(MAX_HALF) : half_cols;
  end

  // frame size, registered; stable by the time any command looks at it
  logic [OUT_W-1:0] total;
  always_ff @(posedge clk) begin
    total <= OUT_W'(rows * cols);
  end

  state_t state, state_next;

  // latched transaction
  entry_t entry;

  // position counters
  logic [ROW_W-1:0] in_row;
  logic [COL_W-1:0] in_col;
  logic [OUT_W-1:0] out_count;

  // output register handshake
  logic out_free;
  logic out_load;
  assign out_free = !result_valid || !result_stall;

  logic accept;
  assign accept = item_valid && !item_stall;

  // row closing before a pixel is stored, then frame restart
  logic              col_over;
  logic [ROW_W:0]    row_pre;
  logic              frame_over;
  logic [ROW_W-1:0]  row0;
  logic [COL_W-1:0]  col0;

  always_comb begin
    col_over   = ({1'b0, in_col} >= cols);
    row_pre    = col_over ? ({1'b0, in_row} + 1'b1) : {1'b0, in_row};
    frame_over = (row_pre >= {1'b0, rows});
    row0       = frame_over ? '0 : row_pre[ROW_W-1:0];
    col0       = (frame_over || col_over) ? '0 : in_col;
  end

  // line store slots
  entry_t           slot_rd [SLOTS];
  logic [SLOTS-1:0] slot_wr;

  for (genvar s = 0; s < SLOTS; s++) begin : g_slot
    assign slot_wr[s] = (state == ST_SHIFT) && (in_row[SLOT_W-1:0] == SLOT_W'(s));
    fws_line_slot u_slot (
      .clk     (clk),
      .wr_en   (slot_wr[s]),
      .wr_addr (in_col),
      .wr_data (entry),
      .rd_en   (state == ST_PREP),
      .rd_addr (col0),
      .rd_data (slot_rd[s])
    );
  end

  // window: chain of row cells, the newest row at the bottom
  entry_t [SPAN-1:0] win [SPAN];
  entry_t            row_din [SPAN];

  for (genvar j = 0; j < SPAN; j++) begin : g_row
    if (j < SLOTS) begin : g_old
      assign row_din[j] = slot_rd[SLOT_W'(in_row[SLOT_W-1:0] + SLOT_W'(j))];
    end else begin : g_new
      assign row_din[j] = entry;
    end
    fws_row_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (state == ST_SHIFT),
      .din   (row_din[j]),
      .taps  (win[j])
    );
  end

  // emit test for the pixel just stored
  logic [OUT_W:0]   lin;
  logic [CCNT_W:0]  lag;

  // divider for output row and column
  logic              div_start;
  logic              div_done;
  logic [OUT_W-1:0]  out_pr;
  logic [CCNT_W-1:0] out_pc;

  fws_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (out_count),
    .divisor   (cols),
    .done      (div_done),
    .quotient  (out_pr),
    .remainder (out_pc)
  );

  logic border;
  assign border = (out_pr < OUT_W'(hr))
               || ((OUT_W + 1)'(out_pr) + (OUT_W + 1)'(hr) >= (OUT_W + 1)'(rows))
               || (out_pc < CCNT_W'(hc))
               || (out_pc + CCNT_W'(hc) >= cols);

  // window walk for the multiply-accumulate
  logic [SPAN_W-1:0] row_base, col_base;
  logic [SPAN_W-1:0] jj, kk;
  logic [WIDX_W-1:0] wq;
  logic [SPAN_W-1:0] span_r, span_c;
  logic              walk_last;
  entry_t            tap;
  entry_t            centre;

  assign row_base  = SPAN_W'(SLOTS) - {hr, 1'b0};
  assign col_base  = SPAN_W'(SLOTS) - {hc, 1'b0};
  assign span_r    = {hr, 1'b0};
  assign span_c    = {hc, 1'b0};
  assign walk_last = (jj == span_r) && (kk == span_c);
  assign tap       = win[SPAN_W'(row_base + jj)][SPAN_W'(col_base + kk)];
  assign centre    = win[SPAN_W'(SLOTS) - SPAN_W'(hr)][SPAN_W'(SLOTS) - SPAN_W'(hc)];

  logic signed [WEIGHT_BITS-1:0] weights [NUM_WEIGHTS];

  logic signed [SAMPLE_BITS+WEIGHT_BITS-1:0] prod;
  logic                                      prod_ok;
  logic signed [SUM_BITS-1:0]                acc;
  logic                                      any_na;
  logic                                      any_valid;
  logic signed [SUM_BITS-1:0]                acc_fin;

  assign acc_fin = acc + (prod_ok ? SUM_BITS'(prod) : '0);

  // pending result
  logic signed [SUM_BITS-1:0] pend_value;
  logic                       pend_na;

  logic flush_due;
  assign flush_due = (in_row >= rows) && (out_count < total);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (cmd == CMD_PIXEL) begin
            state_next = ST_PREP;
          end else if (cmd == CMD_FLUSH) begin
            state_next = ST_FLUSH;
          end
        end
      end
      ST_PREP:  state_next = ST_SHIFT;
      ST_SHIFT: state_next = ST_CHECK;
      ST_CHECK: begin
        if ((lin < (OUT_W + 1)'(lag)) || (out_count >= total)) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (border || (skip_na && fill_na_only && !centre.na)) begin
            state_next = ST_EMIT;
          end else begin
            state_next = ST_MAC;
          end
        end
      end
      ST_MAC:     state_next = walk_last ? ST_MAC_END : ST_MAC;
      ST_MAC_END: state_next = ST_EMIT;
      ST_EMIT:    state_next = out_free ? ST_IDLE : ST_EMIT;
      ST_FLUSH: begin
        if (!flush_due || out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    item_stall = 1'b1;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE:  item_stall = 1'b0;
      ST_CHECK: div_start  = !((lin < (OUT_W + 1)'(lag)) || (out_count >= total));
      ST_EMIT:  out_load   = out_free;
      ST_FLUSH: out_load   = flush_due && out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // weight store
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_WEIGHTS; i++) begin
        weights[i] <= '0;
      end
    end else if (accept && cmd == CMD_WEIGHT && weight_index < WIDX_W'(NUM_WEIGHTS)) begin
      weights[weight_index] <= sample;
    end
  end

  // latch pixel of the transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      entry.value <= sample;
      entry.na    <= sample_na;
    end
  end

  // position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      in_row    <= '0;
      in_col    <= '0;
      out_count <= '0;
    end else begin
      if (state == ST_PREP) begin
        in_row <= row0;
        in_col <= col0;
        if (frame_over) begin
          out_count <= '0;
        end
      end else if (state == ST_SHIFT) begin
        if ({1'b0, in_col} + 1'b1 >= cols) begin
          in_col <= '0;
          in_row <= in_row + 1'b1;
        end else begin
          in_col <= in_col + 1'b1;
        end
      end
      if (out_load) begin
        out_count <= out_count + 1'b1;
      end
    end
  end

  // emit distance, taken before the column advances
  always_ff @(posedge clk) begin
    if (state == ST_SHIFT) begin
      lin <= (OUT_W + 1)'(in_row * cols) + (OUT_W + 1)'(in_col);
      lag <= (CCNT_W + 1)'(hr * cols) + (CCNT_W + 1)'(hc);
    end
  end

  // window walk and accumulation
  always_ff @(posedge clk) begin
    if (state == ST_DIV) begin
      jj        <= '0;
      kk        <= '0;
      wq        <= '0;
      prod_ok   <= 1'b0;
      acc       <= '0;
      any_na    <= 1'b0;
      any_valid <= 1'b0;
      if (border) begin
        pend_na    <= 1'b1;
        pend_value <= '0;
      end else begin
        // fill-only with a valid centre: centre scaled to the sum format
        pend_na    <= 1'b0;
        pend_value <= SUM_BITS'(centre.value) <<< WEIGHT_FRAC;
      end
    end else if (state == ST_MAC) begin
      acc <= acc_fin;
      if (tap.na) begin
        any_na  <= 1'b1;
        prod_ok <= 1'b0;
      end else begin
        any_valid <= 1'b1;
        prod_ok   <= 1'b1;
        prod      <= tap.value * weights[wq];
      end
      wq <= wq + 1'b1;
      if (kk == span_c) begin
        kk <= '0;
        jj <= jj + 1'b1;
      end else begin
        kk <= kk + 1'b1;
      end
    end else if (state == ST_MAC_END) begin
      pend_na    <= skip_na ? !any_valid : any_na;
      pend_value <= (skip_na ? !any_valid : any_na) ? '0 : acc_fin;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sum_value  <= (state == ST_FLUSH) ? '0 : pend_value;
      sum_na     <= (state == ST_FLUSH) ? 1'b1 : pend_na;
      frame_last <= ((OUT_W + 1)'(out_count) + 1'b1 == (OUT_W + 1)'(total));
    end
  end

endmodule
